// ===== sv/bdpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdpa_pkg
// Widths and constants of the base-10000 dot-product accumulator.
// ----------------------------------------------------------------------------
package bdpa_pkg;

  localparam int unsigned DigW = 14;   // one base-10000 digit
  localparam int unsigned AccW = 32;   // running accumulator
  localparam int unsigned CntW = 16;   // wrap count
  localparam int unsigned ProdW = 2 * DigW;
  localparam int unsigned Q1W = 19;    // acc / 10^4 < 300000
  localparam int unsigned Q2W = 5;     // acc / 10^8 < 30
  localparam int unsigned RemW = 15;   // partial remainder before correction

  localparam logic [AccW-1:0] AccBase   = 32'd3000000000;
  localparam logic [AccW-1:0] DigitBase = 32'd10000;

  // floor(2^45 / 10^4): quotient estimate is exact or one low for acc < 2^32
  localparam int unsigned     Recip1Shift = 45;
  localparam logic [AccW-1:0] Recip1      = 32'd3518437208;
  // floor(2^32 / 10^4): same property for a 19-bit dividend
  localparam int unsigned     Recip2Shift = 32;
  localparam logic [Q1W-1:0]  Recip2      = 19'd429496;

  // AccBase / 10^8, weight of one wrap in the high part
  localparam logic [CntW-1:0] HighScale = 16'd30;

endpackage

`default_nettype wire

// ===== sv/base10000_dot_product_accumulator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base10000_dot_product_accumulator_top
// Accumulates x*y digit products; on the last term emits two base-10000
// digits and a high part of the dot product and clears its running state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one digit pair per
//   request plus a last-term mark. The product is folded into the
//   accumulator in the cycle the request is taken, so one term is taken
//   every cycle while in_stall_o is low.
//   Only a last-term request yields an output request (low, mid, high).
//   It runs through a five-register chain: captured sum, reciprocal
//   multiply for /10^4, remainder correction, reciprocal multiply for
//   /10^8, final correction into the output register.
//   Throughput: one term per cycle; the division chain is the only thing
//   that can hold the input.
//   Output stall backs up the chain stage by stage; in_stall_o rises only
//   when the captured-sum register is full and cannot move on.
//   Reset clears the accumulator, the wrap count and all valid flags.
// ----------------------------------------------------------------------------
module base10000_dot_product_accumulator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [bdpa_pkg::DigW-1:0]     x_digit_i,
  input  wire logic [bdpa_pkg::DigW-1:0]     y_digit_i,
  input  wire logic                          last_term_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [bdpa_pkg::DigW-1:0]     low_digit_o,
  output      logic [bdpa_pkg::DigW-1:0]     mid_digit_o,
  output      logic [bdpa_pkg::CntW-1:0]     high_part_o
);
  import bdpa_pkg::*;

  // running state
  logic [AccW-1:0]  acc_q, acc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // stage valids
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;

  // stage payloads
  logic [AccW-1:0]  s1_acc_q, s2_acc_q;
  logic [CntW-1:0]  s1_cnt_q;
  logic [CntW-1:0]  s2_hi_q, s3_hi_q, s4_hi_q;
  logic [Q1W-1:0]   s2_qest_q, s3_q1_q, s4_q1_q;
  logic [DigW-1:0]  s3_r0_q, s4_r0_q;
  logic [Q2W-1:0]   s4_qest_q;
  logic [DigW-1:0]  low_q, mid_q;
  logic [CntW-1:0]  high_q;

  logic             in_acc;
  logic [ProdW-1:0] prod;
  logic [AccW-1:0]  sum_raw, sum_fin;
  logic [CntW-1:0]  cnt_fin;
  logic [2*AccW-1:0] p1;
  logic [AccW-1:0]  r1_full;
  logic [RemW-1:0]  r1;
  logic [Q1W-1:0]   q1_fix;
  logic [DigW-1:0]  r0_fix;
  logic [2*Q1W-1:0] p2;
  logic [Q1W-1:0]   r2_full;
  logic [RemW-1:0]  r2;
  logic [Q2W-1:0]   q2_fix;
  logic [DigW-1:0]  r1_fix;

  // backpressure chain
  assign out_rdy = !out_vld_q || !out_stall_i;
  assign s4_rdy  = !s4_vld_q || out_rdy;
  assign s3_rdy  = !s3_vld_q || s4_rdy;
  assign s2_rdy  = !s2_vld_q || s3_rdy;
  assign s1_rdy  = !s1_vld_q || s2_rdy;

  assign in_stall_o = !s1_rdy;
  assign in_acc     = in_valid_i && !in_stall_o;

  // multiply-accumulate with one conditional wrap
  always_comb begin
    prod    = x_digit_i * y_digit_i;
    sum_raw = acc_q + AccW'(prod);
    sum_fin = sum_raw;
    cnt_fin = cnt_q;
    if (sum_raw >= AccBase) begin
      sum_fin = sum_raw - AccBase;
      cnt_fin = cnt_q + CntW'(1);
    end
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      if (last_term_i) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = sum_fin;
        cnt_d = cnt_fin;
      end
    end
  end

  // acc / 10^4 estimate
  assign p1 = {{AccW{1'b0}}, s1_acc_q} * {{AccW{1'b0}}, Recip1};

  // remainder and correction for /10^4
  always_comb begin
    r1_full = s2_acc_q - AccW'(s2_qest_q) * DigitBase;
    r1      = r1_full[RemW-1:0];
    q1_fix  = s2_qest_q;
    r0_fix  = r1[DigW-1:0];
    if (r1 >= RemW'(DigitBase)) begin
      q1_fix = s2_qest_q + Q1W'(1);
      r0_fix = DigW'(r1 - RemW'(DigitBase));
    end
  end

  // q1 / 10^4 estimate
  assign p2 = {{Q1W{1'b0}}, s3_q1_q} * {{Q1W{1'b0}}, Recip2};

  // remainder and correction for the second digit
  always_comb begin
    r2_full = s4_q1_q - Q1W'(s4_qest_q) * Q1W'(DigitBase);
    r2      = r2_full[RemW-1:0];
    q2_fix  = s4_qest_q;
    r1_fix  = r2[DigW-1:0];
    if (r2 >= RemW'(DigitBase)) begin
      q2_fix = s4_qest_q + Q2W'(1);
      r1_fix = DigW'(r2 - RemW'(DigitBase));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      cnt_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      if (s1_rdy)  s1_vld_q  <= in_acc && last_term_i;
      if (s2_rdy)  s2_vld_q  <= s1_vld_q;
      if (s3_rdy)  s3_vld_q  <= s2_vld_q;
      if (s4_rdy)  s4_vld_q  <= s3_vld_q;
      if (out_rdy) out_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_acc && last_term_i) begin
      s1_acc_q <= sum_fin;
      s1_cnt_q <= cnt_fin;
    end
    if (s2_rdy && s1_vld_q) begin
      s2_acc_q  <= s1_acc_q;
      s2_qest_q <= p1[Recip1Shift +: Q1W];
      s2_hi_q   <= CntW'(s1_cnt_q * HighScale);
    end
    if (s3_rdy && s2_vld_q) begin
      s3_q1_q <= q1_fix;
      s3_r0_q <= r0_fix;
      s3_hi_q <= s2_hi_q;
    end
    if (s4_rdy && s3_vld_q) begin
      s4_q1_q   <= s3_q1_q;
      s4_qest_q <= p2[Recip2Shift +: Q2W];
      s4_r0_q   <= s3_r0_q;
      s4_hi_q   <= s3_hi_q;
    end
    if (out_rdy && s4_vld_q) begin
      low_q  <= s4_r0_q;
      mid_q  <= r1_fix;
      high_q <= s4_hi_q + CntW'(q2_fix);
    end
  end

  assign out_valid_o = out_vld_q;
  assign low_digit_o = low_q;
  assign mid_digit_o = mid_q;
  assign high_part_o = high_q;

  // accumulator never holds a value at or above the wrap point
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q < AccBase)
    else $error("accumulator out of range");

  // last term clears running state
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_term_i |=> acc_q == '0 && cnt_q == '0)
    else $error("state not cleared after last term");

  // input is only held back by a full, blocked capture stage
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q && s2_vld_q && s3_vld_q && s4_vld_q && out_vld_q)
    else $error("input stalled with room in the chain");

  // emitted digits are proper base-10000 digits
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> low_q < DigW'(DigitBase) && mid_q < DigW'(DigitBase))
    else $error("output digit out of range");

endmodule

`default_nettype wire

// ===== tb/base10000_dot_product_accumulator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base10000_dot_product_accumulator_top_tb
// Feeds digit-pair vectors (directed extremes, random vectors and one long
// vector that wraps the accumulator many times) and checks every emitted
// digit triple against a cycle-free model of the accumulator, under random
// bursts on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module base10000_dot_product_accumulator_top_tb;
  import bdpa_pkg::*;

  localparam logic [31:0] DotWrap    = 32'd3000000000;
  localparam logic [31:0] DigitRadix = 32'd10000;
  localparam logic [31:0] HighRadix  = 32'd100000000;
  localparam logic [31:0] WrapWeight = 32'd30;
  localparam int          CycleLimit = 1000000;
  localparam int          TailCycles = 20;
  localparam int          HoldAtTerm = 500;
  localparam int          HoldCycles = 400;
  localparam int          LongTerms  = 350;
  localparam int          RandTerms  = 650;

  typedef struct packed {
    logic [DigW-1:0] x;
    logic [DigW-1:0] y;
    logic            last;
    logic            drain;  // sender waits here until all results are back
  } term_t;

  typedef struct packed {
    logic [DigW-1:0] low;
    logic [DigW-1:0] mid;
    logic [CntW-1:0] high;
  } digits_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [DigW-1:0] x_digit_i   = '0;
  logic [DigW-1:0] y_digit_i   = '0;
  logic            last_term_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [DigW-1:0] low_digit_o;
  logic [DigW-1:0] mid_digit_o;
  logic [CntW-1:0] high_part_o;

  term_t   term_queue[$];
  digits_t digits_due[$];
  digits_t want;

  logic [31:0]     acc_sum  = '0;
  logic [CntW-1:0] wrap_cnt = '0;

  logic req_taken  = 1'b0;
  bit   failed     = 1'b0;
  int   terms_taken = 0;
  int   cycle_cnt  = 0;

  int   burst_left = 0;
  int   gap_left   = 0;
  int   stall_mode = 0;
  int   mode_left  = 0;
  int   hold_left  = 0;
  bit   hold_done  = 1'b0;

  base10000_dot_product_accumulator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_digit_i   (x_digit_i),
    .y_digit_i   (y_digit_i),
    .last_term_i (last_term_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .low_digit_o (low_digit_o),
    .mid_digit_o (mid_digit_o),
    .high_part_o (high_part_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("base10000_dot_product_accumulator_top_tb NOT OK");
      $finish;
    end
  end

  // Fold one accepted term into the running sum; a last term yields digits.
  task automatic fold_term(input logic [DigW-1:0] x, input logic [DigW-1:0] y,
                           input logic last);
    logic [31:0] sum;
    logic [31:0] high;
    digits_t     d;
    sum = acc_sum + 32'(x) * 32'(y);
    if (sum >= DotWrap) begin
      sum = sum - DotWrap;
      wrap_cnt = wrap_cnt + 1'b1;
    end
    acc_sum = sum;
    if (last) begin
      high   = acc_sum / HighRadix + WrapWeight * 32'(wrap_cnt);
      d.low  = DigW'(acc_sum % DigitRadix);
      d.mid  = DigW'((acc_sum / DigitRadix) % DigitRadix);
      d.high = CntW'(high);
      digits_due.push_back(d);
      acc_sum  = '0;
      wrap_cnt = '0;
    end
  endtask

  task automatic push_term(input int x, input int y, input bit last);
    term_t t;
    t.x = DigW'(x);
    t.y = DigW'(y);
    t.last = last;
    t.drain = 1'b0;
    term_queue.push_back(t);
  endtask

  task automatic push_drain();
    term_t t;
    t = '0;
    t.drain = 1'b1;
    term_queue.push_back(t);
  endtask

  function automatic int pick_digit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 9999);
    if (r < 65) return $urandom_range(0, 16383);
    if (r < 75) return ($urandom_range(0, 1) != 0) ? 9999 : 16383;
    if (r < 85) return 0;
    return $urandom_range(9000, 16383);
  endfunction

  // request acceptance on the input side
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      req_taken <= 1'b1;
      terms_taken <= terms_taken + 1;
      fold_term(x_digit_i, y_digit_i, last_term_i);
    end else begin
      req_taken <= 1'b0;
    end
  end

  // sender: bursts of requests with random gaps, payload held while stalled
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (term_queue.size() != 0 && term_queue[0].drain) begin
        if (digits_due.size() == 0) void'(term_queue.pop_front());
        in_valid_i <= 1'b0;
      end else if (term_queue.size() != 0) begin
        in_valid_i  <= 1'b1;
        x_digit_i   <= term_queue[0].x;
        y_digit_i   <= term_queue[0].y;
        last_term_i <= term_queue[0].last;
        void'(term_queue.pop_front());
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern in spans of changing density, plus one long hold
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (!hold_done && terms_taken >= HoldAtTerm) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left = mode_left - 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (stall_mode == 0) begin
        out_stall_i <= 1'b0;
      end else if (stall_mode == 1) begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digits_due.size() == 0) begin
        $error("result with none expected: low %0d mid %0d high %0d",
               low_digit_o, mid_digit_o, high_part_o);
        failed = 1'b1;
      end else begin
        want = digits_due.pop_front();
        if (low_digit_o !== want.low) begin
          $error("low_digit: expected %0d, got %0d", want.low, low_digit_o);
          failed = 1'b1;
        end
        if (mid_digit_o !== want.mid) begin
          $error("mid_digit: expected %0d, got %0d", want.mid, mid_digit_o);
          failed = 1'b1;
        end
        if (high_part_o !== want.high) begin
          $error("high_part: expected %0d, got %0d", want.high, high_part_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int queued;
    int len;
    int r;

    // single-term vectors at the field extremes
    push_term(0, 0, 1'b1);
    push_term(9999, 9999, 1'b1);
    push_term(16383, 16383, 1'b1);
    push_term(16383, 0, 1'b1);
    push_term(0, 16383, 1'b1);
    push_term(14'h2AAA, 14'h1555, 1'b1);
    push_term(14'h1555, 14'h2AAA, 1'b1);
    // non-last terms only update the sum
    push_term(1, 9999, 1'b0);
    push_term(10000, 10000, 1'b1);
    // twelve max products cross the wrap point once
    for (int i = 0; i < 12; i++) push_term(16383, 16383, i == 11);
    push_drain();

    queued = 0;
    while (queued < RandTerms) begin
      r = $urandom_range(0, 99);
      if (r < 45)      len = $urandom_range(1, 2);
      else if (r < 88) len = $urandom_range(3, 12);
      else             len = $urandom_range(13, 256);
      for (int i = 0; i < len; i++) push_term(pick_digit(), pick_digit(), i == len - 1);
      queued = queued + len;
    end
    push_drain();

    // many wraps in one vector lift the high part to 939
    for (int i = 0; i < LongTerms; i++) push_term(16383, 16383, i == LongTerms - 1);
    push_term(pick_digit(), pick_digit(), 1'b1);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (term_queue.size() != 0 || in_valid_i || digits_due.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (!failed) begin
      $display("base10000_dot_product_accumulator_top_tb OK");
    end else begin
      $display("base10000_dot_product_accumulator_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bdpa_pkg.sv
sv/base10000_dot_product_accumulator_top.sv
tb/base10000_dot_product_accumulator_top_tb.sv
